/* rtl/rfd_pkg.sv */
`default_nettype none

package rfd_pkg;

   localparam int unsigned HEADER_BYTES        = 20;
   localparam int unsigned CONTROL_PAYLOAD_MAX = 64;
   localparam logic [31:0] WIRE_MAGIC          = 32'h534E_5452;

   localparam int unsigned POS_W      = $clog2(HEADER_BYTES + 1);
   localparam int unsigned NUM_CSR    = 3;
   localparam int unsigned CSR_IDX_W  = $clog2(NUM_CSR);
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EXPECTED_VERSION = CSR_IDX_W'(0),
      CSR_MAX_RELIABLE     = CSR_IDX_W'(1),
      CSR_MAX_UNRELIABLE   = CSR_IDX_W'(2)
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_OK               = 4'd0,
      ST_MAGIC            = 4'd1,
      ST_VERSION_MISMATCH = 4'd2,
      ST_VERSION_ZERO     = 4'd3,
      ST_KIND             = 4'd4,
      ST_CHANNEL          = 4'd5,
      ST_APP_TOO_LONG     = 4'd6,
      ST_CTRL_WRONG_CHAN  = 4'd7,
      ST_CTRL_TOO_LONG    = 4'd8,
      ST_INCOMPLETE       = 4'd9,
      ST_TRAILING         = 4'd10
   } status_type;

   typedef enum logic [2:0] {
      KIND_APPLICATION       = 3'd0,
      KIND_TCP_HELLO         = 3'd1,
      KIND_TCP_HELLO_ACK     = 3'd2,
      KIND_UDP_ASSOCIATE     = 3'd3,
      KIND_UDP_ASSOCIATE_ACK = 3'd4
   } kind_type;

   typedef enum logic {
      CH_RELIABLE   = 1'b0,
      CH_UNRELIABLE = 1'b1
   } channel_type;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_PAYLOAD = 3'b010,
      PH_DROP    = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  payload_byte;
      logic        payload_valid;
      logic        last;
      logic [2:0]  packet_kind;
      logic        packet_channel;
      logic [63:0] header_tick;
      logic [31:0] payload_length;
   } rsp_type;

   typedef struct packed {
      logic [15:0] expected_version;
      logic [31:0] max_reliable_payload;
      logic [31:0] max_unreliable_payload;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      expected_version:       16'd1,
      max_reliable_payload:   32'd1048576,
      max_unreliable_payload: 32'd1200
   };

endpackage

`default_nettype wire

/* rtl/rfd_ifs.sv */
`default_nettype none

interface rfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_buffer;

   modport source (output valid, data_byte, end_of_buffer, input ready);
   modport sink   (input valid, data_byte, end_of_buffer, output ready);
endinterface

interface rfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [7:0]  payload_byte;
   logic        payload_valid;
   logic        last;
   logic [2:0]  packet_kind;
   logic        packet_channel;
   logic [63:0] header_tick;
   logic [31:0] payload_length;

   modport source (output valid, status, payload_byte, payload_valid, last, packet_kind,
                   packet_channel, header_tick, payload_length, input ready);
   modport sink   (input valid, status, payload_byte, payload_valid, last, packet_kind,
                   packet_channel, header_tick, payload_length, output ready);
endinterface

interface rfd_csr_if import rfd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/rfd_csr.sv */
`default_nettype none

module rfd_csr import rfd_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   rfd_csr_if.sink    csr,
   output cfg_type    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.index)
            CSR_EXPECTED_VERSION: cfg_in.expected_version       = csr.data[15:0];
            CSR_MAX_RELIABLE:     cfg_in.max_reliable_payload   = csr.data[31:0];
            CSR_MAX_UNRELIABLE:   cfg_in.max_unreliable_payload = csr.data[31:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/rfd_in_stage.sv */
`default_nettype none

module rfd_in_stage import rfd_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   rfd_req_if.sink    req,
   input  wire logic  advance,
   output logic       item_valid,
   output req_type    item
);

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;
   logic    take;

   assign req.ready  = !valid_ff || advance;
   assign take       = req.valid && req.ready;
   assign item_valid = valid_ff;
   assign item       = data_ff;

   always_comb begin
      priority if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff.data_byte     <= req.data_byte;
         data_ff.end_of_buffer <= req.end_of_buffer;
      end
   end

endmodule

`default_nettype wire

/* rtl/rfd_core.sv */
`default_nettype none

module rfd_core import rfd_pkg::*; #(
   parameter int unsigned CTRL_PAYLOAD_MAX = CONTROL_PAYLOAD_MAX
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     item_valid,
   input  wire req_type  item,
   input  wire logic     advance,
   input  wire cfg_type  cfg,
   output logic          res_valid,
   output rsp_type       res
);

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in, pos_inc;
   logic [31:0]      remaining_ff, remaining_in, remaining_dec;
   logic [31:0]      magic_ff, magic_sh;
   logic [15:0]      version_ff, version_sh;
   logic [7:0]       kind_ff, kind_sh;
   logic [7:0]       channel_ff, channel_sh;
   logic [63:0]      tick_ff, tick_sh;
   logic [31:0]      length_ff, length_sh;
   logic             hdr_load;
   logic             hit;
   logic             err;
   status_type       err_code;
   status_type       chk;
   logic [7:0]       b;
   logic             eob;
   logic             step;

   function automatic status_type check_header(
      input logic [31:0] magic,
      input logic [15:0] version,
      input logic [7:0]  kind,
      input logic [7:0]  channel,
      input logic [31:0] length,
      input cfg_type     c
   );
      logic [31:0] lim;
      logic        want;
      status_type  code;
      lim  = (channel[0] == CH_RELIABLE) ? c.max_reliable_payload : c.max_unreliable_payload;
      want = (kind == 8'(KIND_TCP_HELLO) || kind == 8'(KIND_TCP_HELLO_ACK))
             ? CH_RELIABLE : CH_UNRELIABLE;
      priority if (magic != WIRE_MAGIC) begin
         code = ST_MAGIC;
      end else if (version != c.expected_version) begin
         code = ST_VERSION_MISMATCH;
      end else if (c.expected_version == 16'd0) begin
         code = ST_VERSION_ZERO;
      end else if (kind > 8'(KIND_UDP_ASSOCIATE_ACK)) begin
         code = ST_KIND;
      end else if (channel[7:1] != 7'd0) begin
         code = ST_CHANNEL;
      end else if (kind == 8'(KIND_APPLICATION)) begin
         code = (length > lim) ? ST_APP_TOO_LONG : ST_OK;
      end else if (channel[0] != want) begin
         code = ST_CTRL_WRONG_CHAN;
      end else if (length > 32'(CTRL_PAYLOAD_MAX)) begin
         code = ST_CTRL_TOO_LONG;
      end else begin
         code = ST_OK;
      end
      return code;
   endfunction

   assign b             = item.data_byte;
   assign eob           = item.end_of_buffer;
   assign step          = item_valid && advance;
   assign pos_inc       = pos_ff + POS_W'(1);
   assign remaining_dec = remaining_ff - 32'd1;

   always_comb begin
      magic_sh   = magic_ff;
      version_sh = version_ff;
      kind_sh    = kind_ff;
      channel_sh = channel_ff;
      tick_sh    = tick_ff;
      length_sh  = length_ff;
      priority if (pos_ff < POS_W'(4)) begin
         magic_sh = {magic_ff[23:0], b};
      end else if (pos_ff < POS_W'(6)) begin
         version_sh = {version_ff[7:0], b};
      end else if (pos_ff == POS_W'(6)) begin
         kind_sh = b;
      end else if (pos_ff == POS_W'(7)) begin
         channel_sh = b;
      end else if (pos_ff < POS_W'(16)) begin
         tick_sh = {tick_ff[55:0], b};
      end else begin
         length_sh = {length_ff[23:0], b};
      end
   end

   assign chk = check_header(magic_sh, version_sh, kind_sh, channel_sh, length_sh, cfg);

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      remaining_in = remaining_ff;
      hdr_load     = 1'b0;
      hit          = 1'b0;
      err          = 1'b0;
      err_code     = ST_OK;
      res          = '0;
      unique case (phase_ff)
         PH_DROP: begin
            if (eob) begin
               phase_in = PH_HEADER;
               pos_in   = '0;
            end
         end
         PH_PAYLOAD: begin
            remaining_in = remaining_dec;
            priority if (remaining_dec == 32'd0 && !eob) begin
               err      = 1'b1;
               err_code = ST_TRAILING;
            end else if (remaining_dec != 32'd0 && eob) begin
               err      = 1'b1;
               err_code = ST_INCOMPLETE;
            end else begin
               hit                = 1'b1;
               res.payload_byte   = b;
               res.payload_valid  = 1'b1;
               res.packet_kind    = kind_ff[2:0];
               res.packet_channel = channel_ff[0];
               res.header_tick    = tick_ff;
               res.payload_length = length_ff;
               if (remaining_dec == 32'd0) begin
                  res.last = 1'b1;
                  phase_in = PH_HEADER;
                  pos_in   = '0;
               end
            end
         end
         default: begin
            phase_in = PH_HEADER;
            hdr_load = 1'b1;
            pos_in   = pos_inc;
            priority if (pos_inc < POS_W'(HEADER_BYTES)) begin
               if (eob) begin
                  err      = 1'b1;
                  err_code = ST_INCOMPLETE;
               end
            end else if (chk != ST_OK) begin
               err      = 1'b1;
               err_code = chk;
            end else if (length_sh == 32'd0) begin
               if (!eob) begin
                  err      = 1'b1;
                  err_code = ST_TRAILING;
               end else begin
                  hit                = 1'b1;
                  res.last           = 1'b1;
                  res.packet_kind    = kind_sh[2:0];
                  res.packet_channel = channel_sh[0];
                  res.header_tick    = tick_sh;
                  res.payload_length = length_sh;
                  pos_in             = '0;
               end
            end else if (eob) begin
               err      = 1'b1;
               err_code = ST_INCOMPLETE;
            end else begin
               remaining_in = length_sh;
               phase_in     = PH_PAYLOAD;
            end
         end
      endcase
      if (err) begin
         hit          = 1'b1;
         res          = '0;
         res.status   = err_code;
         res.last     = 1'b1;
         pos_in       = '0;
         remaining_in = 32'd0;
         phase_in     = eob ? PH_HEADER : PH_DROP;
      end
   end

   assign res_valid = item_valid && hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         pos_ff       <= '0;
         remaining_ff <= 32'd0;
      end else if (step) begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         remaining_ff <= remaining_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && hdr_load) begin
         magic_ff   <= magic_sh;
         version_ff <= version_sh;
         kind_ff    <= kind_sh;
         channel_ff <= channel_sh;
         tick_ff    <= tick_sh;
         length_ff  <= length_sh;
      end
   end

endmodule

`default_nettype wire

/* rtl/rfd_out_stage.sv */
`default_nettype none

module rfd_out_stage import rfd_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     res_valid,
   input  wire rsp_type  res,
   output logic          advance,
   rfd_rsp_if.source     rsp
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign advance  = !valid_ff || rsp.ready;
   assign valid_in = advance ? res_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         data_ff <= res;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.status         = data_ff.status;
   assign rsp.payload_byte   = data_ff.payload_byte;
   assign rsp.payload_valid  = data_ff.payload_valid;
   assign rsp.last           = data_ff.last;
   assign rsp.packet_kind    = data_ff.packet_kind;
   assign rsp.packet_channel = data_ff.packet_channel;
   assign rsp.header_tick    = data_ff.header_tick;
   assign rsp.payload_length = data_ff.payload_length;

endmodule

`default_nettype wire

/* rtl/replication_frame_deframer.sv */
// Results: an accepted byte is held in the input register, and its result is registered
//   in the output register; header bytes give no result except the last one or one
//   that ends the buffer, and dropped bytes give none.
// Throughput: one byte per cycle while results are taken, set by the single pass from input to result register.
// Reset (synchronous): both stages empty, header phase at position zero, registers
//   back to version 1, reliable limit 1048576, unreliable limit 1200.
`default_nettype none

module replication_frame_deframer import rfd_pkg::*; #(
   parameter int unsigned CTRL_PAYLOAD_MAX = CONTROL_PAYLOAD_MAX
) (
   input  wire logic  clock,
   input  wire logic  reset,
   rfd_req_if.sink    req_ch,
   rfd_rsp_if.source  rsp_ch,
   rfd_csr_if.sink    csr_ch
);

   cfg_type cfg;
   logic    advance;
   logic    item_valid;
   req_type item;
   logic    res_valid;
   rsp_type res;

   rfd_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_ch),
      .cfg   (cfg)
   );

   rfd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   rfd_core #(
      .CTRL_PAYLOAD_MAX (CTRL_PAYLOAD_MAX)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .advance    (advance),
      .cfg        (cfg),
      .res_valid  (res_valid),
      .res        (res)
   );

   rfd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .advance   (advance),
      .rsp       (rsp_ch)
   );

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != ST_OK) |-> (rsp_ch.last && !rsp_ch.payload_valid))
      else $error("error result without last or with payload");

   a_payload_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.payload_valid) |-> (rsp_ch.status == ST_OK))
      else $error("payload byte with error status");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (item_valid && rsp_ch.valid && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("transfer taken while both stages are stalled");

   a_capture: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> item_valid)
      else $error("accepted byte not held in input register");

endmodule

`default_nettype wire

/* bench/tb_replication_frame_deframer.sv */
module tb_replication_frame_deframer import rfd_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = CSR_IDX_W'(NUM_CSR);

   class deframe_scoreboard;
      logic [15:0] version_reg;
      logic [31:0] reliable_limit;
      logic [31:0] unreliable_limit;
      phase_type   phase;
      logic [4:0]  position;
      logic [31:0] magic;
      logic [15:0] version;
      logic [7:0]  kind;
      logic [7:0]  channel;
      logic [63:0] tick;
      logic [31:0] length;
      logic [31:0] remaining;
      rsp_type     pending[$];
      int          mismatches;

      function new();
         version_reg      = CFG_RESET.expected_version;
         reliable_limit   = CFG_RESET.max_reliable_payload;
         unreliable_limit = CFG_RESET.max_unreliable_payload;
         phase            = PH_HEADER;
         remaining        = '0;
         mismatches       = 0;
         clear_header();
      endfunction

      function void clear_header();
         position = '0;
         magic    = '0;
         version  = '0;
         kind     = '0;
         channel  = '0;
         tick     = '0;
         length   = '0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_EXPECTED_VERSION: version_reg = val[15:0];
            CSR_MAX_RELIABLE: reliable_limit = val;
            CSR_MAX_UNRELIABLE: unreliable_limit = val;
            default: ;
         endcase
      endfunction

      function status_type header_status();
         logic want;
         if (magic != WIRE_MAGIC) return ST_MAGIC;
         if (version != version_reg) return ST_VERSION_MISMATCH;
         if (version_reg == 16'd0) return ST_VERSION_ZERO;
         if (kind > 8'(KIND_UDP_ASSOCIATE_ACK)) return ST_KIND;
         if (channel > 8'(CH_UNRELIABLE)) return ST_CHANNEL;
         if (kind == 8'(KIND_APPLICATION)) begin
            if (length > (channel[0] ? unreliable_limit : reliable_limit)) return ST_APP_TOO_LONG;
            return ST_OK;
         end
         want = (kind == 8'(KIND_TCP_HELLO) || kind == 8'(KIND_TCP_HELLO_ACK)) ?
                CH_RELIABLE : CH_UNRELIABLE;
         if (channel[0] != want) return ST_CTRL_WRONG_CHAN;
         if (length > CONTROL_PAYLOAD_MAX) return ST_CTRL_TOO_LONG;
         return ST_OK;
      endfunction

      function rsp_type header_result();
         rsp_type r;
         r                = '0;
         r.status         = ST_OK;
         r.packet_kind    = kind[2:0];
         r.packet_channel = channel[0];
         r.header_tick    = tick;
         r.payload_length = length;
         return r;
      endfunction

      function void reject(status_type code, logic eob);
         rsp_type r;
         r        = '0;
         r.status = code;
         r.last   = 1'b1;
         pending.insert(pending.size(), r);
         clear_header();
         remaining = '0;
         phase     = eob ? PH_HEADER : PH_DROP;
      endfunction

      function void note_transfer(logic [7:0] b, logic eob);
         rsp_type    r;
         status_type code;
         if (phase == PH_DROP) begin
            if (eob) begin
               phase = PH_HEADER;
               clear_header();
            end
            return;
         end
         if (phase == PH_PAYLOAD) begin
            remaining = remaining - 32'd1;
            if (remaining == 0 && !eob) begin
               reject(ST_TRAILING, eob);
               return;
            end
            if (remaining != 0 && eob) begin
               reject(ST_INCOMPLETE, eob);
               return;
            end
            r               = header_result();
            r.payload_byte  = b;
            r.payload_valid = 1'b1;
            if (remaining == 0) begin
               r.last = 1'b1;
               phase  = PH_HEADER;
               clear_header();
            end
            pending.insert(pending.size(), r);
            return;
         end
         phase = PH_HEADER;
         if (position < 4) magic = {magic[23:0], b};
         else if (position < 6) version = {version[7:0], b};
         else if (position == 6) kind = b;
         else if (position == 7) channel = b;
         else if (position < 16) tick = {tick[55:0], b};
         else length = {length[23:0], b};
         position = position + 5'd1;
         if (position < HEADER_BYTES) begin
            if (eob) reject(ST_INCOMPLETE, eob);
            return;
         end
         code = header_status();
         if (code != ST_OK) begin
            reject(code, eob);
            return;
         end
         if (length == 0) begin
            if (!eob) begin
               reject(ST_TRAILING, eob);
               return;
            end
            r      = header_result();
            r.last = 1'b1;
            pending.insert(pending.size(), r);
            clear_header();
            return;
         end
         if (eob) begin
            reject(ST_INCOMPLETE, eob);
            return;
         end
         remaining = length;
         phase     = PH_PAYLOAD;
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: status %0d byte %h valid %b last %b", got.status,
                        got.payload_byte, got.payload_valid, got.last);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("expected: status %0d byte %h valid %b last %b kind %0d chan %b",
                        want.status, want.payload_byte, want.payload_valid, want.last,
                        want.packet_kind, want.packet_channel);
               $display("          tick %h length %h", want.header_tick, want.payload_length);
               $display("actual:   status %0d byte %h valid %b last %b kind %0d chan %b",
                        got.status, got.payload_byte, got.payload_valid, got.last,
                        got.packet_kind, got.packet_channel);
               $display("          tick %h length %h", got.header_tick, got.payload_length);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   rfd_req_if req_if ();
   rfd_rsp_if rsp_if ();
   rfd_csr_if csr_if ();

   replication_frame_deframer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   deframe_scoreboard sb;
   logic [7:0]        frame_q[$];
   rsp_type           seen;
   int                burst_left = 0;
   int                bytes_sent = 0;
   int                cycles = 0;
   int                stall_left = 0;
   int                stall_mode = 0;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(4, 60);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_if.ready <= 1'b1;
         1: rsp_if.ready <= 1'($urandom_range(0, 1));
         2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
         default: rsp_if.ready <= ~rsp_if.ready;
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         seen.status         = status_type'(rsp_if.status);
         seen.payload_byte   = rsp_if.payload_byte;
         seen.payload_valid  = rsp_if.payload_valid;
         seen.last           = rsp_if.last;
         seen.packet_kind    = rsp_if.packet_kind;
         seen.packet_channel = rsp_if.packet_channel;
         seen.header_tick    = rsp_if.header_tick;
         seen.payload_length = rsp_if.payload_length;
         sb.check_result(seen);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eob);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                  : $urandom_range(1, 12);
         gap = $urandom_range(1, 6);
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid         = 1'b1;
      req_if.data_byte     = b;
      req_if.end_of_buffer = eob;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_transfer(b, eob);
      burst_left--;
      bytes_sent++;
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_q.size(); i++)
         send_byte(frame_q[i], i == frame_q.size() - 1);
      frame_q.delete();
   endtask

   task automatic settle();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.index = idx;
      csr_if.data  = val;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      sb.set_register(idx, val);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic write_all(input logic [15:0] ver, input logic [31:0] rel,
                            input logic [31:0] unrel);
      settle();
      write_register(CSR_EXPECTED_VERSION, {16'($urandom), ver});
      write_register(CSR_MAX_RELIABLE, rel);
      write_register(CSR_MAX_UNRELIABLE, unrel);
   endtask

   function automatic void put_header(logic [31:0] m, logic [15:0] v, logic [7:0] k,
                                      logic [7:0] c, logic [63:0] t, logic [31:0] n);
      logic [159:0] h;
      h = {m, v, k, c, t, n};
      for (int i = 19; i >= 0; i--) frame_q.insert(frame_q.size(), h[i*8 +: 8]);
   endfunction

   function automatic void put_payload(int n);
      repeat (n) frame_q.insert(frame_q.size(), 8'($urandom));
   endfunction

   function automatic logic [7:0] control_channel(logic [7:0] k);
      return (k == 8'(KIND_TCP_HELLO) || k == 8'(KIND_TCP_HELLO_ACK)) ?
             8'(CH_RELIABLE) : 8'(CH_UNRELIABLE);
   endfunction

   task automatic frame(input logic [31:0] m, input logic [15:0] v, input logic [7:0] k,
                        input logic [7:0] c, input logic [63:0] t, input logic [31:0] n,
                        input int count);
      put_header(m, v, k, c, t, n);
      put_payload(count);
      send_frame();
   endtask

   task automatic cut_frame(input int keep);
      put_header(WIRE_MAGIC, sb.version_reg, 8'(KIND_APPLICATION), 8'(CH_RELIABLE),
                 {$urandom, $urandom}, 32'd4);
      while (frame_q.size() > keep) void'(frame_q.pop_back());
      send_frame();
   endtask

   task automatic random_frame();
      int          sel;
      int          n;
      int          keep;
      logic [31:0] m;
      logic [31:0] len;
      logic [31:0] lim;
      logic [15:0] v;
      logic [7:0]  k;
      logic [7:0]  c;
      sel  = $urandom_range(0, 99);
      keep = HEADER_BYTES + 1000;
      m    = WIRE_MAGIC;
      v    = sb.version_reg;
      k    = 8'($urandom_range(0, 4));
      if (k == 8'(KIND_APPLICATION)) begin
         c   = 8'($urandom_range(0, 1));
         lim = c[0] ? sb.unreliable_limit : sb.reliable_limit;
         len = $urandom_range(0, (lim < 40) ? lim : 40);
      end else begin
         c   = control_channel(k);
         len = ($urandom_range(0, 3) == 0) ? CONTROL_PAYLOAD_MAX : $urandom_range(0, 20);
      end
      n = len;
      if (sel >= 95) begin
         put_payload($urandom_range(1, 30));
         send_frame();
         return;
      end else if (sel >= 91) begin
         keep = $urandom_range(1, HEADER_BYTES - 1);
      end else if (sel >= 86) begin
         n = len + $urandom_range(1, 4);
      end else if (sel >= 81) begin
         if (len == 0) begin
            len = 32'd1;
            n   = 0;
         end else begin
            n = $urandom_range(0, len - 1);
         end
      end else if (sel >= 77) begin
         k = 8'($urandom_range(1, 4));
         c = control_channel(k);
         if (sel < 79) begin
            c = c ^ 8'd1;
         end else begin
            len = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'(65 + $urandom_range(0, 100));
            n   = $urandom_range(0, 4);
         end
      end else if (sel >= 75) begin
         k   = 8'(KIND_APPLICATION);
         c   = 8'($urandom_range(0, 1));
         lim = c[0] ? sb.unreliable_limit : sb.reliable_limit;
         len = (lim == 32'hFFFF_FFFF) ? lim : lim + 32'd1;
         n   = $urandom_range(0, 4);
      end else if (sel >= 73) begin
         c = 8'($urandom_range(2, 255));
      end else if (sel >= 71) begin
         k = 8'($urandom_range(5, 255));
      end else if (sel >= 68) begin
         v = v ^ (16'd1 << $urandom_range(0, 15));
      end else if (sel >= 65) begin
         m = m ^ (32'd1 << $urandom_range(0, 31));
      end
      put_header(m, v, k, c, {$urandom, $urandom}, len);
      put_payload(n);
      while (frame_q.size() > keep) void'(frame_q.pop_back());
      send_frame();
   endtask

   initial begin
      int target;
      sb                   = new();
      req_if.valid         = 1'b0;
      req_if.data_byte     = '0;
      req_if.end_of_buffer = 1'b0;
      rsp_if.ready         = 1'b0;
      csr_if.valid         = 1'b0;
      csr_if.index         = '0;
      csr_if.data          = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      frame(WIRE_MAGIC, 16'd1, 8'(KIND_APPLICATION), 8'(CH_RELIABLE), '1, 32'd3, 3);
      frame(WIRE_MAGIC, 16'd1, 8'(KIND_APPLICATION), 8'(CH_UNRELIABLE), '0, 32'd0, 0);
      frame(32'hFFFF_FFFF, 16'd1, 8'(KIND_APPLICATION), 8'(CH_RELIABLE), '1, 32'd1, 1);
      frame(32'h0, 16'd1, 8'(KIND_APPLICATION), 8'(CH_RELIABLE), '0, 32'd1, 1);
      frame(WIRE_MAGIC, 16'd2, 8'(KIND_APPLICATION), 8'(CH_RELIABLE), '0, 32'd1, 1);
      frame(WIRE_MAGIC, 16'hFFFF, 8'(KIND_APPLICATION), 8'(CH_RELIABLE), '0, 32'd1, 1);
      frame(WIRE_MAGIC, 16'd1, 8'd5, 8'(CH_RELIABLE), '0, 32'd1, 1);
      frame(WIRE_MAGIC, 16'd1, 8'hFF, 8'(CH_RELIABLE), '0, 32'd1, 1);
      frame(WIRE_MAGIC, 16'd1, 8'(KIND_APPLICATION), 8'd2, '0, 32'd1, 1);
      frame(WIRE_MAGIC, 16'd1, 8'(KIND_TCP_HELLO), 8'hFF, '0, 32'd1, 1);
      frame(WIRE_MAGIC, 16'd1, 8'(KIND_APPLICATION), 8'(CH_UNRELIABLE), '0, 32'd1201, 2);
      frame(WIRE_MAGIC, 16'd1, 8'(KIND_APPLICATION), 8'(CH_RELIABLE), '0, 32'hFFFF_FFFF, 2);
      frame(WIRE_MAGIC, 16'd1, 8'(KIND_TCP_HELLO), 8'(CH_UNRELIABLE), '0, 32'd1, 1);
      frame(WIRE_MAGIC, 16'd1, 8'(KIND_UDP_ASSOCIATE), 8'(CH_RELIABLE), '0, 32'd1, 1);
      frame(WIRE_MAGIC, 16'd1, 8'(KIND_UDP_ASSOCIATE_ACK), 8'(CH_UNRELIABLE), '0, 32'd65, 1);
      frame(WIRE_MAGIC, 16'd1, 8'(KIND_TCP_HELLO_ACK), 8'(CH_RELIABLE), '1, 32'd64, 64);
      frame(WIRE_MAGIC, 16'd1, 8'(KIND_TCP_HELLO), 8'(CH_RELIABLE), '0, 32'd2, 2);
      frame(WIRE_MAGIC, 16'd1, 8'(KIND_UDP_ASSOCIATE), 8'(CH_UNRELIABLE), '1, 32'd0, 0);
      cut_frame(1);
      cut_frame(HEADER_BYTES - 1);
      frame(WIRE_MAGIC, 16'd1, 8'(KIND_APPLICATION), 8'(CH_RELIABLE), '0, 32'd5, 2);
      frame(WIRE_MAGIC, 16'd1, 8'(KIND_APPLICATION), 8'(CH_RELIABLE), '0, 32'd2, 4);
      frame(WIRE_MAGIC, 16'd1, 8'(KIND_APPLICATION), 8'(CH_UNRELIABLE), '0, 32'd0, 3);
      frame(WIRE_MAGIC, 16'd1, 8'(KIND_APPLICATION), 8'(CH_RELIABLE), '0, 32'd4, 0);

      write_all(16'd0, 32'd0, 32'hFFFF_FFFF);
      write_register(CSR_UNUSED_INDEX, $urandom);
      frame(WIRE_MAGIC, 16'd0, 8'(KIND_APPLICATION), 8'(CH_RELIABLE), '0, 32'd1, 1);
      frame(WIRE_MAGIC, 16'd1, 8'(KIND_APPLICATION), 8'(CH_RELIABLE), '0, 32'd1, 1);
      write_all(16'hFFFF, 32'd0, 32'hFFFF_FFFF);
      frame(WIRE_MAGIC, 16'hFFFF, 8'(KIND_APPLICATION), 8'(CH_RELIABLE), '0, 32'd1, 1);
      frame(WIRE_MAGIC, 16'hFFFF, 8'(KIND_APPLICATION), 8'(CH_RELIABLE), '0, 32'd0, 0);
      frame(WIRE_MAGIC, 16'hFFFF, 8'(KIND_APPLICATION), 8'(CH_UNRELIABLE), '0,
            32'hFFFF_FFFF, 3);

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: write_all(CFG_RESET.expected_version, CFG_RESET.max_reliable_payload,
                         CFG_RESET.max_unreliable_payload);
            1: write_all(16'hFFFF, 32'd0, 32'd0);
            2: write_all(16'd0, $urandom, $urandom);
            3: write_all(16'($urandom_range(1, 65535)), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            default: write_all(16'($urandom_range(1, 65535)), $urandom_range(0, 60),
                               $urandom_range(0, 60));
         endcase
         if ($urandom_range(0, 1)) write_register(CSR_UNUSED_INDEX, $urandom);
         target = bytes_sent + 170;
         while (bytes_sent < target) random_frame();
      end

      settle();
      if (sb.mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
